/* design/lzss_pkg.sv */
package lzss_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int MM_W       = 2;
    localparam int BIAS_W     = 12;
    localparam int LEN_W      = 5;
    localparam int FLAGS_W    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MATCH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BIAS = 1'd1;

    localparam logic [MM_W-1:0]    MIN_MATCH_RST   = 2'd3;
    localparam logic [BIAS_W-1:0]  OFFSET_BIAS_RST = 12'd19;
    localparam logic [FLAGS_W-1:0] FLAGS_PER_BYTE  = 4'd8;

endpackage

/* design/lzss_byte_stream_decoder_4k_unit.sv */
// Path: a literal is registered in lit_reg, then moves to the output register in ST_EMIT
// once the output slot is free; each byte of a match is a window read, then a write.
// Flag and first match bytes keep ST_IDLE; s_tready stays low until the last byte is out.
// The registered window read puts ST_READ before the ST_EMIT of each copied byte.
// Reset: aresetn, synchronous, active low, clears control and config state.
// The window is not swept; a fill count returns zero for unwritten entries.
module lzss_byte_stream_decoder_4k_unit #(
    parameter int WINDOW_SIZE = lzss_pkg::WINDOW_SIZE_DEF  // power of two
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lzss_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] in_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lzss_pkg::BYTE_W-1:0]        m_tdata,   // [7:0] out_byte
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [lzss_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [lzss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    localparam int AW = $clog2(WINDOW_SIZE);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        PH_FLAG   = 2'd0,
        PH_DATA   = 2'd1,
        PH_MATCH2 = 2'd2
    } phase_t;

    state_t                            state_reg, state_next;
    phase_t                            phase_reg, phase_next;
    logic [lzss_pkg::MM_W-1:0]         min_match_reg, min_match_next;
    logic [lzss_pkg::BIAS_W-1:0]       offset_bias_reg, offset_bias_next;
    logic [lzss_pkg::BYTE_W-1:0]       flag_bits_reg, flag_bits_next;
    logic [lzss_pkg::FLAGS_W-1:0]      flags_left_reg, flags_left_next;
    logic [lzss_pkg::BYTE_W-1:0]       pos_low_reg, pos_low_next;
    logic [AW-1:0]                     wp_reg, wp_next;
    logic [AW-1:0]                     src_reg, src_next;
    logic [lzss_pkg::LEN_W-1:0]        cnt_reg, cnt_next;
    logic [lzss_pkg::BYTE_W-1:0]       lit_reg, lit_next;
    logic                              from_mem_reg, from_mem_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [lzss_pkg::BYTE_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                              m_tlast_reg, m_tlast_next;

    logic                              accept;
    logic                              slot_free;
    logic                              emit;
    logic [lzss_pkg::FLAGS_W-1:0]      fl_dec;
    logic [lzss_pkg::LEN_W-1:0]        len;
    logic [AW-1:0]                     src_sum;
    logic [lzss_pkg::BYTE_W-1:0]       win_rdata;
    logic [lzss_pkg::BYTE_W-1:0]       win_wdata;

    lzss_win #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (emit),
        .waddr   (wp_reg),
        .wdata   (win_wdata),
        .re      (state_reg == ST_READ),
        .raddr   (src_reg),
        .rdata   (win_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign emit      = (state_reg == ST_EMIT) && slot_free;
    assign win_wdata = from_mem_reg ? win_rdata : lit_reg;
    assign fl_dec    = flags_left_reg - 1'b1;
    assign len       = {1'b0, s_tdata[3:0]} + {3'b000, min_match_reg};
    // position + bias - 1, wrapped to the window
    assign src_sum   = AW'({s_tdata[7:4], pos_low_reg}) + AW'(offset_bias_reg)
                       + {AW{1'b1}};

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        min_match_next   = min_match_reg;
        offset_bias_next = offset_bias_reg;
        flag_bits_next   = flag_bits_reg;
        flags_left_next  = flags_left_reg;
        pos_low_next     = pos_low_reg;
        wp_next          = wp_reg;
        src_next         = src_reg;
        cnt_next         = cnt_reg;
        lit_next         = lit_reg;
        from_mem_next    = from_mem_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tlast_next     = m_tlast_reg;

        if (cfg_we) begin
            case (cfg_addr)
                lzss_pkg::CFG_MIN_MATCH: begin
                    min_match_next = cfg_wdata[lzss_pkg::MM_W-1:0];
                end
                lzss_pkg::CFG_OFFSET_BIAS: begin
                    offset_bias_next = cfg_wdata[lzss_pkg::BIAS_W-1:0];
                end
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (phase_reg)
                        PH_DATA: begin
                            if (flag_bits_reg[0]) begin
                                lit_next        = s_tdata;
                                from_mem_next   = 1'b0;
                                cnt_next        = lzss_pkg::LEN_W'(1);
                                state_next      = ST_EMIT;
                                flag_bits_next  = flag_bits_reg >> 1;
                                flags_left_next = fl_dec;
                                phase_next      = (fl_dec == '0) ? PH_FLAG : PH_DATA;
                            end else begin
                                pos_low_next = s_tdata;
                                phase_next   = PH_MATCH2;
                            end
                        end
                        PH_MATCH2: begin
                            src_next        = src_sum;
                            cnt_next        = len;
                            from_mem_next   = 1'b1;
                            flag_bits_next  = flag_bits_reg >> 1;
                            flags_left_next = fl_dec;
                            phase_next      = (fl_dec == '0) ? PH_FLAG : PH_DATA;
                            if (len != '0) begin
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                            flag_bits_next  = s_tdata;
                            flags_left_next = lzss_pkg::FLAGS_PER_BYTE;
                            phase_next      = PH_DATA;
                        end
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = win_wdata;
                    m_tlast_next  = (cnt_reg == lzss_pkg::LEN_W'(1));
                    wp_next       = wp_reg + 1'b1;
                    src_next      = src_reg + 1'b1;
                    cnt_next      = cnt_reg - 1'b1;
                    state_next    = (cnt_reg == lzss_pkg::LEN_W'(1)) ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_FLAG;
            min_match_reg   <= lzss_pkg::MIN_MATCH_RST;
            offset_bias_reg <= lzss_pkg::OFFSET_BIAS_RST;
            flag_bits_reg   <= '0;
            flags_left_reg  <= '0;
            wp_reg          <= '0;
            cnt_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            min_match_reg   <= min_match_next;
            offset_bias_reg <= offset_bias_next;
            flag_bits_reg   <= flag_bits_next;
            flags_left_reg  <= flags_left_next;
            wp_reg          <= wp_next;
            cnt_reg         <= cnt_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_low_reg  <= pos_low_next;
        src_reg      <= src_next;
        lit_reg      <= lit_next;
        from_mem_reg <= from_mem_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* design/lzss_win.sv */
module lzss_win #(
    parameter int WINDOW_SIZE = lzss_pkg::WINDOW_SIZE_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       we,
    input  logic [$clog2(WINDOW_SIZE)-1:0] waddr,
    input  logic [lzss_pkg::BYTE_W-1:0]    wdata,
    input  logic                       re,
    input  logic [$clog2(WINDOW_SIZE)-1:0] raddr,
    output logic [lzss_pkg::BYTE_W-1:0]    rdata
);
    localparam int AW = $clog2(WINDOW_SIZE);

    logic [lzss_pkg::BYTE_W-1:0] mem [WINDOW_SIZE];
    logic [lzss_pkg::BYTE_W-1:0] mem_q;
    logic [AW:0]                 fill_reg;
    logic [AW:0]                 fill_next;
    logic                        rd_ok_reg;
    logic                        rd_ok_next;

    // writes run in order from address zero, so the fill count marks
    // which entries are still unwritten; reads of those return zero
    always_comb begin
        fill_next = fill_reg;
        if (we && !fill_reg[AW]) begin
            fill_next = fill_reg + 1'b1;
        end
        rd_ok_next = rd_ok_reg;
        if (re) begin
            rd_ok_next = fill_reg[AW] || ({1'b0, raddr} < fill_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            mem_q <= mem[raddr];
        end
    end

    assign rdata = rd_ok_reg ? mem_q : '0;

endmodule

/* design/lzss_chk.sv */
module lzss_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [lzss_pkg::BYTE_W-1:0]     s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lzss_pkg::BYTE_W-1:0]     m_tdata,
    input logic                            m_tlast
);

    // output beat held while stalled
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("m beat changed while stalled");

    a_rst_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

    // more bytes of the same match are pending: input side must stay closed
    a_busy_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open while a match is in flight");

endmodule

bind lzss_byte_stream_decoder_4k_unit lzss_chk u_lzss_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* sim/lzss_byte_stream_decoder_4k_unit_tb.sv */
`timescale 1ns / 100ps

module lzss_byte_stream_decoder_4k_unit_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 48;
    localparam int PHASE_BYTES = 34;

    typedef enum logic [1:0] {
        AWAIT_FLAG     = 2'd0,
        AWAIT_DATA     = 2'd1,
        AWAIT_MATCH_HI = 2'd2
    } dec_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_beat_t;

    class lzss_stream_board;
        logic [7:0]                   window [lzss_pkg::WINDOW_SIZE_DEF];
        logic [11:0]                  wr_pos;
        logic [7:0]                   flag_sr;
        logic [lzss_pkg::FLAGS_W-1:0] flags_left;
        dec_phase_t                   phase;
        logic [7:0]                   pos_low;
        logic [lzss_pkg::MM_W-1:0]    min_match;
        logic [lzss_pkg::BIAS_W-1:0]  offset_bias;
        dec_beat_t                    expected_bytes [$];
        int                           errors;

        function new();
            foreach (window[i]) window[i] = 8'h00;
            wr_pos      = '0;
            flag_sr     = '0;
            flags_left  = '0;
            phase       = AWAIT_FLAG;
            pos_low     = '0;
            min_match   = lzss_pkg::MIN_MATCH_RST;
            offset_bias = lzss_pkg::OFFSET_BIAS_RST;
            errors      = 0;
        endfunction

        function void write_reg(logic [lzss_pkg::CFG_IDX_W-1:0] idx,
                                logic [lzss_pkg::CFG_DATA_W-1:0] val);
            if (idx == lzss_pkg::CFG_MIN_MATCH) begin
                min_match = val[lzss_pkg::MM_W-1:0];
            end else if (idx == lzss_pkg::CFG_OFFSET_BIAS) begin
                offset_bias = val[lzss_pkg::BIAS_W-1:0];
            end
        endfunction

        function void put(logic [7:0] b, logic last);
            dec_beat_t e;
            window[wr_pos] = b;
            wr_pos = wr_pos + 12'd1;
            e.data = b;
            e.last = last;
            expected_bytes.push_back(e);
        endfunction

        function void use_flag();
            flag_sr    = flag_sr >> 1;
            flags_left = flags_left - 1'b1;
            phase      = (flags_left == 0) ? AWAIT_FLAG : AWAIT_DATA;
        endfunction

        function void decode_in_byte(logic [7:0] b);
            logic [11:0] posn;
            logic [11:0] src;
            logic [11:0] rd;
            logic [4:0]  len;
            case (phase)
                AWAIT_DATA: begin
                    if (flag_sr[0]) begin
                        put(b, 1'b1);
                        use_flag();
                    end else begin
                        pos_low = b;
                        phase   = AWAIT_MATCH_HI;
                    end
                end
                AWAIT_MATCH_HI: begin
                    posn = {b[7:4], pos_low};
                    len  = {1'b0, b[3:0]} + {3'b000, min_match};
                    src  = posn + offset_bias - 12'd1;
                    for (int i = 0; i < len; i++) begin
                        rd = src + 12'(i);
                        put(window[rd], i == len - 1);
                    end
                    use_flag();
                end
                default: begin
                    flag_sr    = b;
                    flags_left = lzss_pkg::FLAGS_PER_BYTE;
                    phase      = AWAIT_DATA;
                end
            endcase
        endfunction

        function void check_out_byte(logic [7:0] data, logic last);
            dec_beat_t e;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected beat data %02h last %0b", $time, data, last);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            if (data !== e.data) begin
                $display("%0t: out_byte mismatch exp %02h got %02h", $time, e.data, data);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: tlast mismatch exp %0b got %0b", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [lzss_pkg::BYTE_W-1:0]     s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [lzss_pkg::BYTE_W-1:0]     m_tdata;
    logic                            m_tlast;
    logic                            cfg_we    = 1'b0;
    logic [lzss_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [lzss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    lzss_stream_board board;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  rx_hold_req = 1'b0;
    int  hold_left = 0;
    int  bytes_sent = 0;
    int  cycle_count = 0;

    logic [7:0] dir_a [0:13] = '{8'h0b, 8'h00, 8'hff, 8'hff, 8'hf0, 8'ha5, 8'hf3,
                                 8'hff, 8'h00, 8'h00, 8'h12, 8'h34, 8'h80, 8'h0f};
    logic [7:0] dir_b [0:3]  = '{8'h02, 8'h00, 8'h00, 8'hff};

    logic [1:0] mm_plan [0:5] = '{2'd2, 2'd1, 2'd3, 2'd0, 2'd2, 2'd0};
    int         tx_plan [0:5] = '{0, 57, 0, 19, 0, 0};
    int         rx_plan [0:5] = '{0, 0, 57, 19, 57, 0};

    lzss_byte_stream_decoder_4k_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                board.check_out_byte(m_tdata, m_tlast);
            end
            if (hold_left == 0 && rx_hold_req) begin
                hold_left   = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        board.decode_in_byte(b);
        bytes_sent++;
    endtask

    task automatic drain_idle();
        s_tvalid <= 1'b0;
        while (board.expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [1:0] mm, input logic [11:0] bias);
        cfg_we    <= 1'b1;
        cfg_addr  <= lzss_pkg::CFG_MIN_MATCH;
        cfg_wdata <= {10'd0, mm};
        @(posedge aclk);
        board.write_reg(lzss_pkg::CFG_MIN_MATCH, {10'd0, mm});
        cfg_addr  <= lzss_pkg::CFG_OFFSET_BIAS;
        cfg_wdata <= bias;
        @(posedge aclk);
        board.write_reg(lzss_pkg::CFG_OFFSET_BIAS, bias);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_match();
        logic [11:0] src;
        logic [11:0] posn;
        logic [3:0]  nib;
        int          r;
        r = $urandom_range(99);
        if (r < 70) begin
            src = board.wr_pos - 12'($urandom_range(48, 1));
        end else begin
            src = 12'($urandom_range(4095));
        end
        posn = src - board.offset_bias + 12'd1;
        r = $urandom_range(9);
        nib = (r == 0) ? 4'h0 : (r == 1) ? 4'hf : 4'($urandom_range(15));
        send_byte(posn[7:0]);
        send_byte({posn[11:8], nib});
    endtask

    task automatic send_group();
        logic [7:0] flags;
        while (board.phase != AWAIT_FLAG) send_byte(8'($urandom_range(255)));
        flags = 8'($urandom_range(255));
        send_byte(flags);
        for (int k = 0; k < 8; k++) begin
            if (flags[k]) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                send_match();
            end
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(5, 1);
        repeat (n) send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        int  target;
        bit  paused;
        logic [11:0] bias;
        board = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // literals at both extremes, reads of unwritten window, overlapping copy,
        // position 0 and 0xfff, nibble 0 and 0xf, then flags exhausted
        foreach (dir_a[i]) send_byte(dir_a[i]);
        drain_idle();
        // zero-length match with min_match 0 and maximum bias
        write_cfg(2'd0, 12'hfff);
        foreach (dir_b[i]) send_byte(dir_b[i]);

        for (int p = 0; p < 6; p++) begin
            drain_idle();
            case (p)
                0: bias = 12'd0;
                1: bias = 12'hfff;
                2: bias = 12'd1;
                4: bias = 12'hfff;
                default: bias = 12'($urandom_range(4095));
            endcase
            write_cfg(mm_plan[p], bias);
            tx_idle_pct  = tx_plan[p];
            rx_stall_pct = rx_plan[p];
            if (p == 5) rx_hold_req = 1'b1;
            paused = 1'b0;
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                if (p == 3 && !paused && bytes_sent >= target - PHASE_BYTES / 2) begin
                    drain_idle();
                    paused = 1'b1;
                end
                if ($urandom_range(7) == 0) begin
                    send_noise();
                end else begin
                    send_group();
                end
            end
        end

        drain_idle();
        if (board.errors == 0 && board.expected_bytes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
